/* hdl/i2cmbw_pkg.sv */
// Shared types and constants for the I2C master byte writer.
`timescale 1ns / 1ps
package i2cmbw_pkg;

  localparam int BITS_PER_BYTE = 8;
  localparam int BIT_IDX_W     = $clog2(BITS_PER_BYTE);
  localparam int DELAY_W       = 16;
  localparam logic [DELAY_W-1:0] DELAY_RESET = 16'd5;

  // Line operation for one phase
  typedef logic [2:0] op_t;
  localparam op_t OP_SDA_HI  = 3'd0;
  localparam op_t OP_SDA_LO  = 3'd1;
  localparam op_t OP_SDA_BIT = 3'd2;
  localparam op_t OP_SCL_HI  = 3'd3;
  localparam op_t OP_SCL_LO  = 3'd4;

  // Controller to datapath
  typedef struct packed {
    logic accept;  // latch the incoming byte
    logic emit;    // drive one line phase into the output register
    op_t  op;
    logic last;    // final phase of this byte's run
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic can_emit;  // hold time elapsed and output slot free
  } stat_t;

endpackage

/* hdl/i2cmbw_ctrl.sv */
// Phase sequencer: optional start, eight data bits, ack slot, optional stop.
`timescale 1ns / 1ps
module i2cmbw_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_start,
  input  logic                 in_stop,
  output logic                 in_ready,
  input  i2cmbw_pkg::stat_t    stat,
  output i2cmbw_pkg::cmd_t     cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_START = 3'd1;
  localparam logic [2:0] ST_BIT   = 3'd2;
  localparam logic [2:0] ST_ACK   = 3'd3;
  localparam logic [2:0] ST_STOP  = 3'd4;

  localparam logic [i2cmbw_pkg::BIT_IDX_W-1:0] LAST_BIT =
    i2cmbw_pkg::BIT_IDX_W'(i2cmbw_pkg::BITS_PER_BYTE - 1);

  logic [2:0] state, state_next;
  logic [1:0] phase, phase_next;
  logic [i2cmbw_pkg::BIT_IDX_W-1:0] bit_cnt, bit_cnt_next;
  logic stop_req, stop_req_next;

  assign in_ready = (state == ST_IDLE) && !rst;

  always_comb begin
    state_next    = state;
    phase_next    = phase;
    bit_cnt_next  = bit_cnt;
    stop_req_next = stop_req;
    cmd.accept    = 1'b0;
    cmd.emit      = 1'b0;
    cmd.op        = i2cmbw_pkg::OP_SDA_HI;
    cmd.last      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.accept    = 1'b1;
          stop_req_next = in_stop;
          phase_next    = 2'd0;
          bit_cnt_next  = '0;
          state_next    = in_start ? ST_START : ST_BIT;
        end
      end
      ST_START: begin
        cmd.emit = stat.can_emit;
        unique case (phase)
          2'd0:    cmd.op = i2cmbw_pkg::OP_SDA_HI;
          2'd1:    cmd.op = i2cmbw_pkg::OP_SCL_HI;
          2'd2:    cmd.op = i2cmbw_pkg::OP_SDA_LO;
          default: cmd.op = i2cmbw_pkg::OP_SCL_LO;
        endcase
        if (stat.can_emit) begin
          phase_next = phase + 2'd1;
          if (phase == 2'd3) begin
            phase_next = 2'd0;
            state_next = ST_BIT;
          end
        end
      end
      ST_BIT: begin
        cmd.emit = stat.can_emit;
        unique case (phase)
          2'd0:    cmd.op = i2cmbw_pkg::OP_SDA_BIT;
          2'd1:    cmd.op = i2cmbw_pkg::OP_SCL_HI;
          default: cmd.op = i2cmbw_pkg::OP_SCL_LO;
        endcase
        if (stat.can_emit) begin
          phase_next = phase + 2'd1;
          if (phase == 2'd2) begin
            phase_next = 2'd0;
            if (bit_cnt == LAST_BIT) begin
              state_next = ST_ACK;
            end else begin
              bit_cnt_next = bit_cnt + 1'b1;
            end
          end
        end
      end
      ST_ACK: begin
        cmd.emit = stat.can_emit;
        unique case (phase)
          2'd0:    cmd.op = i2cmbw_pkg::OP_SDA_HI;
          2'd1:    cmd.op = i2cmbw_pkg::OP_SCL_HI;
          default: cmd.op = i2cmbw_pkg::OP_SCL_LO;
        endcase
        cmd.last = (phase == 2'd2) && !stop_req;
        if (stat.can_emit) begin
          phase_next = phase + 2'd1;
          if (phase == 2'd2) begin
            phase_next = 2'd0;
            state_next = stop_req ? ST_STOP : ST_IDLE;
          end
        end
      end
      ST_STOP: begin
        cmd.emit = stat.can_emit;
        unique case (phase)
          2'd0:    cmd.op = i2cmbw_pkg::OP_SDA_LO;
          2'd1:    cmd.op = i2cmbw_pkg::OP_SCL_HI;
          default: cmd.op = i2cmbw_pkg::OP_SDA_HI;
        endcase
        cmd.last = (phase == 2'd2);
        if (stat.can_emit) begin
          phase_next = phase + 2'd1;
          if (phase == 2'd2) begin
            phase_next = 2'd0;
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      phase    <= 2'd0;
      bit_cnt  <= '0;
      stop_req <= 1'b0;
    end else begin
      state    <= state_next;
      phase    <= phase_next;
      bit_cnt  <= bit_cnt_next;
      stop_req <= stop_req_next;
    end
  end

endmodule

/* hdl/i2cmbw_dp.sv */
// Datapath: byte shifter, line levels, hold timer, output register.
`timescale 1ns / 1ps
module i2cmbw_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  i2cmbw_pkg::cmd_t                    cmd,
  output i2cmbw_pkg::stat_t                   stat,
  input  logic [i2cmbw_pkg::BITS_PER_BYTE-1:0] in_byte,
  input  logic                                in_ack,
  input  logic                                delay_we,
  input  logic [i2cmbw_pkg::DELAY_W-1:0]      delay_wdata,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_scl,
  output logic                                out_sda,
  output logic                                out_ack,
  output logic                                out_last
);

  logic [i2cmbw_pkg::DELAY_W-1:0] phase_delay;
  logic [i2cmbw_pkg::DELAY_W-1:0] timer;
  logic [i2cmbw_pkg::BITS_PER_BYTE-1:0] shifter;
  logic ack_reg;
  logic scl_level, sda_level;
  logic scl_level_next, sda_level_next;

  // Next phase may go out once the hold has run and the slot is free
  assign stat.can_emit = (timer <= i2cmbw_pkg::DELAY_W'(1)) && (!out_valid || out_ready);

  always_comb begin
    scl_level_next = scl_level;
    sda_level_next = sda_level;
    unique case (cmd.op)
      i2cmbw_pkg::OP_SDA_HI:  sda_level_next = 1'b1;
      i2cmbw_pkg::OP_SDA_LO:  sda_level_next = 1'b0;
      i2cmbw_pkg::OP_SDA_BIT: sda_level_next = shifter[i2cmbw_pkg::BITS_PER_BYTE-1];
      i2cmbw_pkg::OP_SCL_HI:  scl_level_next = 1'b1;
      i2cmbw_pkg::OP_SCL_LO:  scl_level_next = 1'b0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_delay <= i2cmbw_pkg::DELAY_RESET;
      timer       <= '0;
      scl_level   <= 1'b1;
      sda_level   <= 1'b1;
      out_valid   <= 1'b0;
    end else begin
      if (delay_we) begin
        phase_delay <= delay_wdata;
      end
      if (cmd.emit) begin
        timer     <= phase_delay;
        scl_level <= scl_level_next;
        sda_level <= sda_level_next;
        out_valid <= 1'b1;
      end else begin
        if (timer != '0) begin
          timer <= timer - 1'b1;
        end
        if (out_ready) begin
          out_valid <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      shifter <= in_byte;
      ack_reg <= in_ack;
    end else if (cmd.emit && (cmd.op == i2cmbw_pkg::OP_SDA_BIT)) begin
      shifter <= {shifter[i2cmbw_pkg::BITS_PER_BYTE-2:0], 1'b0};
    end
    if (cmd.emit) begin
      out_scl  <= scl_level_next;
      out_sda  <= sda_level_next;
      out_ack  <= cmd.last & ack_reg;
      out_last <= cmd.last;
    end
  end

endmodule

/* hdl/i2c_master_byte_writer_core.sv */
// I2C master byte writer: top level joining sequencer and datapath.
//
// Usage:
//   s_axis carries one byte per transaction: tdata[7:0] byte, tdata[8] the
//   level the slave drives in the ack clock; tuser[0] asks for a start
//   before the byte, tuser[1] a stop after the ack slot.
//   m_axis carries one transaction per line phase: tdata[0] SCL, tdata[1]
//   SDA, tdata[2] sampled ack (set only with tlast); tlast ends the byte.
//   A byte yields 27 phases, plus 4 with start and 3 with stop (up to 34).
//   Each phase is held by the phase_delay timer. After the byte is accepted
//   the sequencer leaves its idle state, and its first phase is registered
//   once the hold has run and the output slot is free.
//   phase_delay is written with phase_delay_we; reset value 5.
//   One byte is in flight at a time; s_axis_tready rises after its final
//   phase is registered, while that phase may still wait on m_axis.
//   When m_axis_tready is low the output register holds and the sequencer
//   waits; no phase is dropped. Reset (rst, synchronous) releases both
//   lines in the held levels, empties the output and restores phase_delay.
`timescale 1ns / 1ps
module i2c_master_byte_writer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // byte_value[7:0], slave_ack[8], zero
  input  logic [1:0]  s_axis_tuser,   // with_start[0], with_stop[1]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // scl[0], sda[1], ack_seen[2], zero
  output logic        m_axis_tlast,
  input  logic        phase_delay_we,
  input  logic [15:0] phase_delay_wdata
);

  i2cmbw_pkg::cmd_t  cmd;
  i2cmbw_pkg::stat_t stat;
  logic out_scl, out_sda, out_ack;

  i2cmbw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_start (s_axis_tuser[0]),
    .in_stop  (s_axis_tuser[1]),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  i2cmbw_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .in_byte     (s_axis_tdata[7:0]),
    .in_ack      (s_axis_tdata[8]),
    .delay_we    (phase_delay_we),
    .delay_wdata (phase_delay_wdata),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_scl     (out_scl),
    .out_sda     (out_sda),
    .out_ack     (out_ack),
    .out_last    (m_axis_tlast)
  );

  assign m_axis_tdata = {5'd0, out_ack, out_sda, out_scl};

endmodule

/* hdl/i2cmbw_checker.sv */
// Port-level checks for the I2C master byte writer, bound to the top level.
`timescale 1ns / 1ps
module i2cmbw_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata,
  input logic        m_axis_tlast
);

  // One byte at a time: taking a byte closes the input for the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input still open after accepting a byte");

  // Stalled output holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("output changed while stalled");

  // Ack level only reported on the closing phase
  a_ack_only_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tdata[2] == 1'b0))
    else $error("ack reported before the final phase");

  // Final phase always leaves SDA released (ack slot or stop)
  a_last_sda_high: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata[1] == 1'b1))
    else $error("final phase with SDA held low");

endmodule

bind i2c_master_byte_writer_core i2cmbw_checker u_i2cmbw_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

/* tb/sv/i2c_master_byte_writer_core_tb.sv */
// Testbench for the I2C master byte writer core: directed byte table, then random runs.
`timescale 1ns / 1ps
module i2c_master_byte_writer_core_tb;

  localparam int STUCK_LIMIT = 4000;
  localparam int MAX_PRINTS  = 100;
  localparam logic ON_SCL = 1'b1;
  localparam logic ON_SDA = 1'b0;

  typedef struct packed {
    logic scl;
    logic sda;
    logic ack_seen;
    logic last;
  } line_phase_t;

  // typed == 1: phase count and ack of the byte are also checked against the table row
  typedef struct packed {
    logic       typed;
    logic [5:0] phases;
    logic       ack;
  } byte_note_t;

  typedef struct packed {
    logic [7:0] value;
    logic       start;
    logic       stop;
    logic       ack;
    logic [5:0] phases;  // 0: predictor only
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;
  logic        phase_delay_we = 1'b0;
  logic [15:0] phase_delay_wdata = '0;

  line_phase_t        line_phase_q[$];
  byte_note_t         byte_note_q[$];
  logic               line_scl = 1'b1;
  logic               line_sda = 1'b1;
  logic [i2cmbw_pkg::DELAY_W-1:0] cur_delay = i2cmbw_pkg::DELAY_RESET;
  int                 send_idle_pct = 0;
  int                 stall_pct = 0;
  int                 errors = 0;
  int                 phases_seen = 0;
  int                 run_len = 0;
  int                 stuck_cycles = 0;

  i2c_master_byte_writer_core dut (
    .clk              (clk),
    .rst              (rst),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .s_axis_tuser     (s_axis_tuser),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .m_axis_tlast     (m_axis_tlast),
    .phase_delay_we   (phase_delay_we),
    .phase_delay_wdata(phase_delay_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    if (errors < MAX_PRINTS)
      $display("mismatch on line phase %0d: %s expected %0h got %0h",
               phases_seen, what, want, got);
    errors++;
  endtask

  // One write to one line, recorded as the resulting (SCL, SDA) pair
  task automatic drive_line(input logic on_scl, input logic level);
    if (on_scl) line_scl = level;
    else line_sda = level;
    line_phase_q.push_back('{line_scl, line_sda, 1'b0, 1'b0});
  endtask

  task automatic predict_line_phases(input logic [7:0] value, input logic start,
                                     input logic stop, input logic ack);
    line_phase_t tail;
    int i;
    if (start) begin
      drive_line(ON_SDA, 1'b1);
      drive_line(ON_SCL, 1'b1);
      drive_line(ON_SDA, 1'b0);
      drive_line(ON_SCL, 1'b0);
    end
    for (i = i2cmbw_pkg::BITS_PER_BYTE - 1; i >= 0; i--) begin
      drive_line(ON_SDA, value[i]);
      drive_line(ON_SCL, 1'b1);
      drive_line(ON_SCL, 1'b0);
    end
    // ack clock with SDA released
    drive_line(ON_SDA, 1'b1);
    drive_line(ON_SCL, 1'b1);
    drive_line(ON_SCL, 1'b0);
    if (stop) begin
      drive_line(ON_SDA, 1'b0);
      drive_line(ON_SCL, 1'b1);
      drive_line(ON_SDA, 1'b1);
    end
    tail = line_phase_q.pop_back();
    tail.ack_seen = ack;
    tail.last = 1'b1;
    line_phase_q.push_back(tail);
  endtask

  // Input side: predict on every accepted byte
  always @(posedge clk) begin
    if (rst) begin
      line_scl = 1'b1;
      line_sda = 1'b1;
    end else if (s_axis_tvalid && s_axis_tready) begin
      predict_line_phases(s_axis_tdata[7:0], s_axis_tuser[0], s_axis_tuser[1],
                          s_axis_tdata[8]);
    end
  end

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Output side: compare each line phase with the oldest prediction
  always @(posedge clk) begin
    line_phase_t want;
    byte_note_t  note;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (line_phase_q.size() == 0) begin
        report_mismatch("unexpected phase, tdata", 0, m_axis_tdata);
      end else begin
        want = line_phase_q.pop_front();
        if (m_axis_tdata[0] !== want.scl) report_mismatch("scl", want.scl, m_axis_tdata[0]);
        if (m_axis_tdata[1] !== want.sda) report_mismatch("sda", want.sda, m_axis_tdata[1]);
        if (m_axis_tdata[2] !== want.ack_seen)
          report_mismatch("ack_seen", want.ack_seen, m_axis_tdata[2]);
        if (m_axis_tlast !== want.last) report_mismatch("tlast", want.last, m_axis_tlast);
        if (m_axis_tdata[7:3] !== 5'd0) report_mismatch("tdata pad", 0, m_axis_tdata[7:3]);
      end
      phases_seen++;
      run_len++;
      if (m_axis_tlast === 1'b1) begin
        if (byte_note_q.size() != 0) begin
          note = byte_note_q.pop_front();
          if (note.typed) begin
            if (run_len != note.phases) report_mismatch("phases in byte", note.phases, run_len);
            if (m_axis_tdata[2] !== note.ack)
              report_mismatch("table ack", note.ack, m_axis_tdata[2]);
          end
        end
        run_len = 0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles == STUCK_LIMIT) begin
      $display("i2c_master_byte_writer_core test failed");
      $finish;
    end
  end

  // Caller sits at a clock edge; valid stays high into the next call when no gap is drawn
  task automatic send_byte(input logic [7:0] value, input logic start, input logic stop,
                           input logic ack, input logic [5:0] phases);
    byte_note_t note;
    note = '{phases != 6'd0, phases, ack};
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, ack, value};
    s_axis_tuser  <= {stop, start};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    byte_note_q.push_back(note);
  endtask

  task automatic wait_bus_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (line_phase_q.size() != 0) @(posedge clk);
    // last phase may still be held by the timer
    repeat (int'(cur_delay) + 4) @(posedge clk);
  endtask

  task automatic set_phase_delay(input logic [i2cmbw_pkg::DELAY_W-1:0] value);
    phase_delay_we    <= 1'b1;
    phase_delay_wdata <= value;
    cur_delay = value;
    @(posedge clk);
    phase_delay_we <= 1'b0;
  endtask

  // Mostly well-formed writes: start + address, data bytes, stop on the final one
  task automatic send_random_traffic(input int count);
    int sent;
    int len;
    int k;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(9) < 8) begin
        len = $urandom_range(4);
        send_byte(8'($urandom_range(255)), 1'b1, len == 0, $urandom_range(9) == 0, 6'd0);
        for (k = 1; k <= len; k++)
          send_byte(8'($urandom_range(255)), 1'b0, k == len, $urandom_range(9) == 0,
                    6'd0);
        sent += len + 1;
      end else begin
        send_byte(8'($urandom_range(255)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                  1'($urandom_range(1)), 6'd0);
        sent++;
      end
    end
  endtask

  initial begin
    dir_row_t dir_rows [16];
    dir_rows = '{
      '{8'h3C, 1'b0, 1'b0, 1'b0, 6'd27},  // no start, straight from reset levels
      '{8'hA5, 1'b1, 1'b0, 1'b0, 6'd31},
      '{8'h00, 1'b0, 1'b0, 1'b1, 6'd27},
      '{8'hFF, 1'b0, 1'b1, 1'b1, 6'd30},  // stop still carries the ack
      '{8'hFF, 1'b0, 1'b0, 1'b0, 6'd0},   // no start after a stop
      '{8'h80, 1'b1, 1'b1, 1'b0, 6'd34},
      '{8'h01, 1'b1, 1'b1, 1'b1, 6'd34},
      '{8'h55, 1'b1, 1'b0, 1'b0, 6'd0},
      '{8'hAA, 1'b0, 1'b0, 1'b1, 6'd0},
      '{8'h7F, 1'b0, 1'b1, 1'b0, 6'd0},
      '{8'hFE, 1'b1, 1'b0, 1'b1, 6'd0},
      '{8'h00, 1'b1, 1'b1, 1'b0, 6'd34},
      '{8'hFF, 1'b1, 1'b1, 1'b1, 6'd34},
      '{8'h5A, 1'b0, 1'b0, 1'b0, 6'd0},
      '{8'hC3, 1'b1, 1'b0, 1'b0, 6'd0},
      '{8'h3C, 1'b0, 1'b1, 1'b1, 6'd0}
    };
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[r])
      send_byte(dir_rows[r].value, dir_rows[r].start, dir_rows[r].stop, dir_rows[r].ack,
                dir_rows[r].phases);
    wait_bus_idle();

    set_phase_delay(16'd1);
    send_random_traffic(120);
    wait_bus_idle();

    send_idle_pct = 58;
    set_phase_delay(16'd0);
    send_random_traffic(120);
    wait_bus_idle();

    // top of the range, written while idle, then replaced
    set_phase_delay(16'hFFFF);
    repeat (8) @(posedge clk);
    send_idle_pct = 0;
    stall_pct = 58;
    set_phase_delay(16'd3);
    send_random_traffic(120);
    wait_bus_idle();

    send_idle_pct = 27;
    stall_pct = 27;
    set_phase_delay(16'd2);
    send_random_traffic(60);
    wait_bus_idle();
    send_random_traffic(60);
    wait_bus_idle();

    set_phase_delay(16'd300);
    send_random_traffic(8);
    wait_bus_idle();

    if (errors == 0)
      $display("i2c_master_byte_writer_core test passed");
    else
      $display("i2c_master_byte_writer_core test failed");
    $finish;
  end

endmodule
